@@ hw/rtl/cop_pkg.sv @@
package cop_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

	localparam int IDX_W   = 5;
	localparam int COORD_W = 24;
	localparam int RAD_W   = 16;
	localparam int DIFF_W  = COORD_W;
	localparam int RSUM_W  = RAD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int RSQ_W   = 2 * RSUM_W;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic                      req_type;
		logic [IDX_W-1:0]          entry_index;
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
		logic [RAD_W-1:0]          circle_radius;
		logic                      is_alive;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] partner_index;
		logic             hit;
		logic             last;
	} result_t;

	typedef struct packed {
		logic wr;
		logic ld;
		logic scan;
		logic flush;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_idle;
	} dp_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

@@ hw/rtl/circle_overlap_pair_finder.sv @@
// Write beat: taken while busy is low, busy stays low, no result; writes go one per cycle while busy is low.
// Query of entry i: busy through the load, scan, drain and finish states (no scan when entry i is dead);
// the table is read one entry per cycle through a single registered port into compare stages s1, s2, s3.
// Results appear one per strobe; the last one comes in the first cycle with busy low again.
// The receiver cannot stall; reset (arst_n low) clears the alive marks and control state at once.
module circle_overlap_pair_finder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cop_pkg::item_t   item,
	output logic             busy,
	output logic             strobe,
	output cop_pkg::result_t result
);
	import cop_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	cop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (item.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	cop_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

	a_nohit_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.hit |-> result.last)
		else $error("no-hit beat without last");

	a_mid_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("intermediate beat after query ended");

	a_last_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("final beat while still busy");

	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.req_type == REQ_QUERY |=> busy)
		else $error("query accepted but block not busy");

	a_flush_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> stat.pipe_idle)
		else $error("final beat issued with compare pipe in flight");

endmodule

@@ hw/rtl/cop_ctrl.sv @@
module cop_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  cop_pkg::dp_stat_t stat,
	output cop_pkg::ctl_cmd_t cmd,
	output logic              busy
);
	import cop_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && req_type == REQ_QUERY) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD:   state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_idle) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				cmd.wr  = start && req_type == REQ_WRITE;
				cmd.ld  = start && req_type == REQ_QUERY;
			end
			ST_LOAD:   ;
			ST_SCAN:   cmd.scan = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: cmd.flush = 1'b1;
			default:   ;
		endcase
	end

endmodule

@@ hw/rtl/cop_datapath.sv @@
module cop_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cop_pkg::item_t    item,
	input  cop_pkg::ctl_cmd_t cmd,
	output cop_pkg::dp_stat_t stat,
	output logic              strobe,
	output cop_pkg::result_t  result
);
	import cop_pkg::*;

	logic [COORD_W-1:0] cx_mem [NUM_ENTRIES];
	logic [COORD_W-1:0] cy_mem [NUM_ENTRIES];
	logic [RAD_W-1:0]   r_mem  [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] alive_q;

	logic              idx_ok;
	logic [ADDR_W-1:0] idx_addr;
	logic [ADDR_W-1:0] j_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              issue;

	logic [CNT_W-1:0]   j_q;
	logic               qok_q;
	logic               ld_s1;
	logic [COORD_W-1:0] xi_q, yi_q;
	logic [RAD_W-1:0]   ri_q;

	logic [COORD_W-1:0] rdx_s1, rdy_s1;
	logic [RAD_W-1:0]   rdr_s1;
	logic               ra_s1, v_s1;
	logic [ADDR_W-1:0]  j_s1;

	logic [DIFF_W-1:0]  dx_s2, dy_s2;
	logic [RSUM_W-1:0]  rs_s2;
	logic               v_s2;
	logic [ADDR_W-1:0]  j_s2;

	logic [SQ_W-1:0]    dx2_s3, dy2_s3;
	logic [RSQ_W-1:0]   rs2_s3;
	logic               v_s3;
	logic [ADDR_W-1:0]  j_s3;

	logic [COORD_W:0]   ddx, ddy;
	logic [COORD_W:0]   mdx, mdy;
	logic [SQ_W:0]      dsum;
	logic               hit_c;

	logic               pend_q;
	logic [ADDR_W-1:0]  pend_idx_q;
	logic               strobe_q;
	result_t            res_q;

	assign idx_ok   = int'(item.entry_index) < NUM_ENTRIES;
	assign idx_addr = ADDR_W'(item.entry_index);
	assign j_addr   = j_q[ADDR_W-1:0];
	assign rd_addr  = cmd.ld ? idx_addr : j_addr;

	assign stat.scan_done = !qok_q || (j_q >= CNT_W'(NUM_ENTRIES));
	assign stat.pipe_idle = !v_s1 && !v_s2 && !v_s3;
	assign issue          = cmd.scan && !stat.scan_done;

	// table storage, one read port with registered data
	always_ff @(posedge clk) begin
		if (cmd.wr && idx_ok) begin
			cx_mem[idx_addr] <= item.centre_x;
			cy_mem[idx_addr] <= item.centre_y;
			r_mem[idx_addr]  <= item.circle_radius;
		end
		rdx_s1 <= cx_mem[rd_addr];
		rdy_s1 <= cy_mem[rd_addr];
		rdr_s1 <= r_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (cmd.wr && idx_ok) begin
			alive_q[idx_addr] <= item.is_alive;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q   <= '0;
			qok_q <= 1'b0;
			ld_s1 <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			ld_s1 <= cmd.ld;
			v_s1  <= issue;
			v_s2  <= v_s1 && ra_s1;
			v_s3  <= v_s2;
			if (cmd.ld) begin
				j_q   <= CNT_W'(int'(item.entry_index) + 1);
				qok_q <= idx_ok && alive_q[idx_addr];
			end else if (issue) begin
				j_q <= j_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		ddx = {xi_q[COORD_W-1], xi_q} - {rdx_s1[COORD_W-1], rdx_s1};
		ddy = {yi_q[COORD_W-1], yi_q} - {rdy_s1[COORD_W-1], rdy_s1};
		mdx = ddx[COORD_W] ? (~ddx + (COORD_W+1)'(1)) : ddx;
		mdy = ddy[COORD_W] ? (~ddy + (COORD_W+1)'(1)) : ddy;
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			xi_q <= rdx_s1;
			yi_q <= rdy_s1;
			ri_q <= rdr_s1;
		end
		ra_s1 <= alive_q[j_addr];
		j_s1  <= j_addr;

		dx_s2 <= mdx[DIFF_W-1:0];
		dy_s2 <= mdy[DIFF_W-1:0];
		rs_s2 <= RSUM_W'(ri_q) + RSUM_W'(rdr_s1);
		j_s2  <= j_s1;

		dx2_s3 <= dx_s2 * dx_s2;
		dy2_s3 <= dy_s2 * dy_s2;
		rs2_s3 <= rs_s2 * rs_s2;
		j_s3   <= j_s2;
	end

	assign dsum  = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign hit_c = v_s3 && (dsum < (SQ_W+1)'(rs2_s3));

	// a hit is held back one beat so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.flush) begin
				strobe_q <= 1'b1;
				pend_q   <= 1'b0;
			end else if (hit_c) begin
				strobe_q <= pend_q;
				pend_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			res_q.partner_index <= pend_q ? IDX_W'(pend_idx_q) : '0;
			res_q.hit           <= pend_q;
			res_q.last          <= 1'b1;
		end else if (hit_c) begin
			res_q.partner_index <= IDX_W'(pend_idx_q);
			res_q.hit           <= 1'b1;
			res_q.last          <= 1'b0;
			pend_idx_q          <= j_s3;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

@@ sim/testbench.sv @@
module testbench;

	import cop_pkg::*;

	localparam int N_DIR          = 21;
	localparam int N_RAND         = 290;
	localparam int FILL_AT        = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 48;

	localparam result_t NO_PARTNER = '{partner_index: '0, hit: 1'b0, last: 1'b1};

	typedef struct {
		item_t   beat;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	// shadow copy of the circle table
	logic signed [COORD_W-1:0] circ_x    [NUM_ENTRIES];
	logic signed [COORD_W-1:0] circ_y    [NUM_ENTRIES];
	logic [RAD_W-1:0]          circ_r    [NUM_ENTRIES];
	bit                        circ_live [NUM_ENTRIES];

	result_t  partner_q [$];
	dir_row_t dir_tab   [N_DIR];

	logic signed [COORD_W-1:0] clus_x;
	logic signed [COORD_W-1:0] clus_y;

	int errors      = 0;
	int n_writes    = 0;
	int n_queries   = 0;
	int n_hits      = 0;
	int n_empty     = 0;
	int idle_cycles = 0;

	circle_overlap_pair_finder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic void add_want(result_t r);
		partner_q.insert(partner_q.size(), r);
	endfunction

	function automatic bit circles_cross(int i, int j);
		longint dx;
		longint dy;
		longint rs;
		dx = longint'(circ_x[i]) - longint'(circ_x[j]);
		dy = longint'(circ_y[i]) - longint'(circ_y[j]);
		rs = longint'(circ_r[i]) + longint'(circ_r[j]);
		return dx * dx + dy * dy < rs * rs;
	endfunction

	function automatic void predict_partners(item_t b);
		result_t r;
		int      found;
		int      i;
		found = 0;
		i = int'(b.entry_index);
		if (b.req_type == REQ_WRITE) begin
			circ_x[i]    = b.centre_x;
			circ_y[i]    = b.centre_y;
			circ_r[i]    = b.circle_radius;
			circ_live[i] = b.is_alive;
		end else begin
			if (circ_live[i]) begin
				for (int j = i + 1; j < NUM_ENTRIES; j++) begin
					if (circ_live[j] && circles_cross(i, j)) begin
						r.partner_index = j[IDX_W-1:0];
						r.hit           = 1'b1;
						r.last          = 1'b0;
						add_want(r);
						found++;
					end
				end
			end
			if (found == 0)
				add_want(NO_PARTNER);
			else
				partner_q[partner_q.size()-1].last = 1'b1;
		end
	endfunction

	function automatic item_t wr_beat(int idx, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [RAD_W-1:0] rad, bit alive);
		item_t b;
		b.req_type      = REQ_WRITE;
		b.entry_index   = idx[IDX_W-1:0];
		b.centre_x      = x;
		b.centre_y      = y;
		b.circle_radius = rad;
		b.is_alive      = alive;
		return b;
	endfunction

	function automatic item_t q_beat(int idx);
		item_t b;
		b = '0;
		b.req_type    = REQ_QUERY;
		b.entry_index = idx[IDX_W-1:0];
		return b;
	endfunction

	function automatic dir_row_t row(item_t b);
		return '{beat: b, typed: 1'b0, want: NO_PARTNER};
	endfunction

	function automatic dir_row_t row_typed(item_t b, result_t want);
		return '{beat: b, typed: 1'b1, want: want};
	endfunction

	// mostly writes clustered around a moving point so that queries find partners;
	// one stretch fills the whole table at one spot and queries entry 0
	function automatic item_t random_beat(int k);
		item_t b;
		if (k % 64 == 0) begin
			clus_x = COORD_W'($urandom);
			clus_y = COORD_W'($urandom);
		end
		b.req_type      = ($urandom_range(9) < 6) ? REQ_WRITE : REQ_QUERY;
		b.entry_index   = IDX_W'($urandom);
		b.centre_x      = COORD_W'($urandom);
		b.centre_y      = COORD_W'($urandom);
		b.circle_radius = RAD_W'($urandom);
		b.is_alive      = 1'($urandom);
		if (k >= FILL_AT && k < FILL_AT + NUM_ENTRIES) begin
			b = wr_beat(k - FILL_AT, clus_x, clus_y, 16'h0100, 1'b1);
		end else if (k == FILL_AT + NUM_ENTRIES) begin
			b.req_type    = REQ_QUERY;
			b.entry_index = '0;
		end else if (b.req_type == REQ_WRITE && $urandom_range(9) < 7) begin
			b.centre_x      = clus_x + COORD_W'($urandom_range(8191)) - 24'd4096;
			b.centre_y      = clus_y + COORD_W'($urandom_range(8191)) - 24'd4096;
			b.circle_radius = RAD_W'($urandom_range(16'h1200));
			b.is_alive      = ($urandom_range(4) != 0);
		end
		return b;
	endfunction

	initial begin
		item_t   beat;
		bit      typed;
		result_t want;
		int      burst_left;
		int      gap;

		dir_tab = '{
			row_typed(q_beat(0), NO_PARTNER),
			row_typed(q_beat(31), NO_PARTNER),
			row(wr_beat(0, 24'h000000, 24'h000000, 16'h0100, 1'b1)),
			row(wr_beat(1, 24'h000200, 24'h000000, 16'h0100, 1'b1)),
			row(wr_beat(2, 24'h0001FF, 24'h000000, 16'h0100, 1'b1)),
			row(wr_beat(3, 24'h000000, 24'h000000, 16'hFFFF, 1'b0)),
			row(q_beat(0)),
			row(wr_beat(31, 24'h800000, 24'h800000, 16'hFFFF, 1'b1)),
			row(wr_beat(30, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b1)),
			row(wr_beat(29, 24'h800000, 24'h800000, 16'h0000, 1'b1)),
			row(q_beat(29)),
			row(q_beat(30)),
			row_typed(q_beat(31), NO_PARTNER),
			row(wr_beat(5, 24'h000000, 24'h000000, 16'h0000, 1'b1)),
			row(wr_beat(6, 24'h000000, 24'h000000, 16'h0000, 1'b1)),
			row(q_beat(5)),
			row(wr_beat(3, 24'h000000, 24'h000000, 16'hFFFF, 1'b1)),
			row(q_beat(0)),
			row(wr_beat(2, 24'h0001FF, 24'h000000, 16'h0100, 1'b0)),
			row(q_beat(0)),
			row(q_beat(1))
		};
		for (int k = 0; k < NUM_ENTRIES; k++)
			circ_live[k] = 1'b0;
		clus_x = '0;
		clus_y = '0;
		burst_left = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < N_DIR + N_RAND; n++) begin
			if (n < N_DIR) begin
				beat  = dir_tab[n].beat;
				typed = dir_tab[n].typed;
				want  = dir_tab[n].want;
			end else begin
				beat  = random_beat(n - N_DIR);
				typed = 1'b0;
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			start <= 1'b1;
			item  <= beat;
			do @(posedge clk); while (busy);
			burst_left--;
			if (beat.req_type == REQ_WRITE)
				n_writes++;
			else
				n_queries++;
			if (typed)
				add_want(want);
			else
				predict_partners(beat);
		end
		start <= 1'b0;

		while (partner_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d table writes and %0d overlap queries", n_writes, n_queries);
		$display("checked %0d partner beats and %0d empty-query beats", n_hits, n_empty);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (result.hit)
				n_hits++;
			else
				n_empty++;
			if (partner_q.size() == 0) begin
				$error("unexpected result beat: partner_index %0d hit %0b last %0b",
					result.partner_index, result.hit, result.last);
				errors++;
			end else begin
				want = partner_q.pop_front();
				if (result.partner_index !== want.partner_index) begin
					$error("partner_index: expected %0d, got %0d",
						want.partner_index, result.partner_index);
					errors++;
				end
				if (result.hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, result.hit);
					errors++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, result.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
